FILE: rtl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg: shared constants for the axis-angle rotation matrix block
// Fixed-point scales, pipeline depths and Taylor divisors.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [15:0] Q14_ONE  = 16'd16384;

  localparam int TAYLOR_TERMS = 6;
  // fold, square, three stages per term, quadrant
  localparam int SC_LAT       = 3 + 3 * TAYLOR_TERMS;
  localparam int DIV_QW       = 32;
  localparam int SQRT_STEPS   = 32;

  function automatic int sin_fact(input int k);
    return (2 * k) * (2 * k + 1);
  endfunction

  function automatic int cos_fact(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

endpackage

FILE: rtl/aar_delay.sv
// ----------------------------------------------------------------------------
// aar_delay: enable-gated delay line
// Aligns side data with the long arithmetic paths.
// ----------------------------------------------------------------------------
module aar_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: rtl/aar_div.sv
// ----------------------------------------------------------------------------
// aar_div: pipelined restoring divider
// One quotient bit per stage; needs num >> QW below den.
// ----------------------------------------------------------------------------
module aar_div #(
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [QW-1:0] qb  [QW];
  logic [DW-1:0] dv  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign low_in = low[k-1];
      assign q_in   = qb[k-1];
      assign d_in   = dv[k-1];
    end

    assign t    = {rem_in, low_in[QW-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low[k] <= {low_in[QW-2:0], 1'b0};
        qb[k]  <= {q_in[QW-2:0], ge};
        dv[k]  <= d_in;
      end
    end
  end

  assign quo = qb[QW-1];

endmodule

FILE: rtl/aar_sqrt.sv
// ----------------------------------------------------------------------------
// aar_sqrt: pipelined integer square root
// Floor root of a 62-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module aar_sqrt
  import aar_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] m,
  output logic [30:0] root
);

  logic [63:0] nr [SQRT_STEPS];
  logic [63:0] rr [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] n_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign n_in = 64'(m);
      assign r_in = '0;
    end else begin : g_next
      assign n_in = nr[j-1];
      assign r_in = rr[j-1];
    end

    assign trial = r_in + BIT;
    assign ge    = n_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        nr[j] <= ge ? n_in - trial : n_in;
        rr[j] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
      end
    end
  end

  assign root = rr[SQRT_STEPS-1][30:0];

endmodule

FILE: rtl/aar_sincos.sv
// ----------------------------------------------------------------------------
// aar_sincos: pipelined sine and cosine in Q2.30
// Octant fold, Taylor series term by term, quadrant signs.
// ----------------------------------------------------------------------------
module aar_sincos
  import aar_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [31:0] sin_q30,
  output logic signed [31:0] cos_q30,
  output logic signed [33:0] omc
);

  typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

  typedef struct packed {
    logic [29:0]        x2;
    logic [30:0]        st;
    logic [30:0]        ct;
    logic signed [32:0] ssum;
    logic signed [32:0] csum;
    logic               sw;
    quad_t              q;
  } it_t;

  // fold
  logic [13:0] r;
  logic        sw_n;
  logic [14:0] rf;
  logic [46:0] fp;
  logic [29:0] s1_x;
  logic        s1_sw;
  quad_t       s1_q;
  logic [59:0] xx;

  assign r    = angle[13:0];
  assign sw_n = r > 14'd8192;
  assign rf   = sw_n ? 15'd16384 - {1'b0, r} : {1'b0, r};
  assign fp   = 47'(rf) * 47'(PI_Q30) + 47'd16384;
  assign xx   = 60'(s1_x) * 60'(s1_x);

  it_t it_q [TAYLOR_TERMS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x  <= fp[44:15];
      s1_sw <= sw_n;
      s1_q  <= quad_t'(angle[15:14]);
      it_q[0].x2   <= xx[59:30];
      it_q[0].st   <= {1'b0, s1_x};
      it_q[0].ct   <= Q30_ONE;
      it_q[0].ssum <= $signed(33'(s1_x));
      it_q[0].csum <= $signed(33'(Q30_ONE));
      it_q[0].sw   <= s1_sw;
      it_q[0].q    <= s1_q;
    end
  end

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    localparam int          DS  = sin_fact(k);
    localparam int          DC  = cos_fact(k);
    localparam logic [63:0] RS  = (64'd1 << 32) / DS;
    localparam logic [63:0] RC  = (64'd1 << 32) / DC;
    localparam bit          NEG = (k % 2) == 1;

    it_t         a_it, b_it;
    logic [60:0] a_sp, a_cp;
    logic [30:0] b_sa, b_ca;
    logic [63:0] b_sr, b_cr;
    logic [30:0] sq0, cq0, st_n, ct_n;
    logic [39:0] srem, crem;

    // reciprocal estimate is low by at most one
    assign sq0  = b_sr[62:32];
    assign cq0  = b_cr[62:32];
    assign srem = 40'(b_sa) - 40'(sq0) * 40'(DS);
    assign crem = 40'(b_ca) - 40'(cq0) * 40'(DC);
    assign st_n = (srem >= 40'(DS)) ? sq0 + 31'd1 : sq0;
    assign ct_n = (crem >= 40'(DC)) ? cq0 + 31'd1 : cq0;

    always_ff @(posedge clk) begin
      if (en) begin
        a_it <= it_q[k-1];
        a_sp <= 61'(it_q[k-1].st) * 61'(it_q[k-1].x2);
        a_cp <= 61'(it_q[k-1].ct) * 61'(it_q[k-1].x2);
        b_it <= a_it;
        b_sa <= a_sp[60:30];
        b_ca <= a_cp[60:30];
        b_sr <= 64'(a_sp[60:30]) * RS;
        b_cr <= 64'(a_cp[60:30]) * RC;
        it_q[k].x2 <= b_it.x2;
        it_q[k].st <= st_n;
        it_q[k].ct <= ct_n;
        it_q[k].sw <= b_it.sw;
        it_q[k].q  <= b_it.q;
        if (NEG) begin
          it_q[k].ssum <= b_it.ssum - $signed({2'b00, st_n});
          it_q[k].csum <= b_it.csum - $signed({2'b00, ct_n});
        end else begin
          it_q[k].ssum <= b_it.ssum + $signed({2'b00, st_n});
          it_q[k].csum <= b_it.csum + $signed({2'b00, ct_n});
        end
      end
    end
  end

  // swap back from the folded octant, then quadrant signs
  logic signed [32:0] fs, fc, s_n, c_n;

  assign fs = it_q[TAYLOR_TERMS].sw ? it_q[TAYLOR_TERMS].csum : it_q[TAYLOR_TERMS].ssum;
  assign fc = it_q[TAYLOR_TERMS].sw ? it_q[TAYLOR_TERMS].ssum : it_q[TAYLOR_TERMS].csum;

  always_comb begin
    case (it_q[TAYLOR_TERMS].q)
      QUAD0:   begin s_n = fs;  c_n = fc;  end
      QUAD1:   begin s_n = fc;  c_n = -fs; end
      QUAD2:   begin s_n = -fs; c_n = -fc; end
      QUAD3:   begin s_n = -fc; c_n = fs;  end
      default: begin s_n = fs;  c_n = fc;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q30 <= 32'(s_n);
      cos_q30 <= 32'(c_n);
      omc     <= $signed(34'(Q30_ONE)) - 34'(c_n);
    end
  end

endmodule

FILE: rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues rotation matrix in Q2.14
// Axis and angle in, nine matrix elements and a zero-axis flag out.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while item_stall is low
// and returns one result per transaction, in order. The path through
// the pipeline that sets its depth is the chain squares -> 32-step square
// root of the normalized axis length -> 32-step divider for the unit axis,
// followed by four stages of multiply, round and saturate; the Taylor
// sine/cosine pipeline (21 stages) and the axis-product dividers run in
// parallel and are delay-matched. Outputs are Q2.14, rounded half away
// from zero and clamped to +-1.0. An all-zero axis gives the identity
// matrix with zero_axis set; the angle is then ignored. A registered
// output plus one skid entry lets the block take a further transaction
// while a result waits; item_stall rises once the skid entry fills and
// drops the cycle after the waiting result is taken. The whole pipeline
// then holds, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix
  import aar_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic [15:0]        angle,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic               zero_axis
);

  // stage levels of the long paths
  localparam int LV_PQ    = 3 + DIV_QW;
  localparam int LV_L     = 3 + SQRT_STEPS;
  localparam int LV_U     = LV_L + 1 + DIV_QW;
  localparam int PQ_DLY   = LV_U - LV_PQ;
  localparam int SIDE_DLY = LV_U - 3;
  localparam int A_DLY    = LV_L - 3;
  localparam int SC_DLY   = LV_U - SC_LAT;

  function automatic logic [32:0] mag34(input logic signed [33:0] a);
    return a[33] ? 33'(-a) : 33'(a);
  endfunction

  function automatic logic [15:0] to_q14(input logic signed [37:0] e);
    logic [37:0] me;
    logic [38:0] rs;
    logic [22:0] mq;
    logic [15:0] m;
    me = e[37] ? 38'(-e) : 38'(e);
    rs = 39'(me) + 39'd32768;
    mq = rs[38:16];
    m  = (mq > 23'(Q14_ONE)) ? Q14_ONE : mq[15:0];
    return e[37] ? 16'(-m) : m;
  endfunction

  logic en;
  logic skid_v, out_v;

  // whole pipeline advances while the skid entry is free
  assign en         = !skid_v;
  assign item_stall = skid_v;

  // ---------------- input register
  logic               r0_v;
  logic signed [15:0] r0_x, r0_y, r0_z;
  logic [15:0]        r0_ang;

  always_ff @(posedge clk) begin
    if (rst) r0_v <= 1'b0;
    else if (en) r0_v <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_x   <= axis_x;
      r0_y   <= axis_y;
      r0_z   <= axis_z;
      r0_ang <= angle;
    end
  end

  // ---------------- magnitudes, squares, cross products
  logic [2:0][15:0] ab0;
  logic             r1_v, r1_zero;
  logic [2:0]       r1_sgn;
  logic [2:0][15:0] r1_ab;
  logic [2:0][31:0] r1_sq, r1_cr;

  assign ab0[0] = r0_x[15] ? 16'(-r0_x) : 16'(r0_x);
  assign ab0[1] = r0_y[15] ? 16'(-r0_y) : 16'(r0_y);
  assign ab0[2] = r0_z[15] ? 16'(-r0_z) : 16'(r0_z);

  always_ff @(posedge clk) begin
    if (rst) r1_v <= 1'b0;
    else if (en) r1_v <= r0_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_ab   <= ab0;
      r1_sgn  <= {r0_z[15], r0_y[15], r0_x[15]};
      r1_zero <= (r0_x == '0) && (r0_y == '0) && (r0_z == '0);
      for (int i = 0; i < 3; i++) r1_sq[i] <= 32'(ab0[i]) * 32'(ab0[i]);
      r1_cr[0] <= 32'(ab0[0]) * 32'(ab0[1]);
      r1_cr[1] <= 32'(ab0[0]) * 32'(ab0[2]);
      r1_cr[2] <= 32'(ab0[1]) * 32'(ab0[2]);
    end
  end

  // ---------------- squared length
  logic             r2_v, r2_zero;
  logic [2:0]       r2_sgn;
  logic [2:0][15:0] r2_ab;
  logic [2:0][31:0] r2_sq, r2_cr;
  logic [31:0]      r2_n2;

  always_ff @(posedge clk) begin
    if (rst) r2_v <= 1'b0;
    else if (en) r2_v <= r1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_n2   <= r1_sq[0] + r1_sq[1] + r1_sq[2];
      r2_ab   <= r1_ab;
      r2_sgn  <= r1_sgn;
      r2_zero <= r1_zero;
      r2_sq   <= r1_sq;
      r2_cr   <= r1_cr;
    end
  end

  // ---------------- normalize for the root, form product numerators
  // even shift that puts the length squared in [2^60, 2^62)
  logic [3:0]       hp;
  logic [4:0]       half_n;
  logic [5:0][63:0] pnum_n;

  always_comb begin
    hp = '0;
    for (int j = 0; j < 16; j++) begin
      if (r2_n2[2*j +: 2] != 2'b00) hp = 4'(j);
    end
  end

  assign half_n = 5'd30 - 5'(hp);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pnum_n[i]     = (64'(r2_sq[i]) << 30) + 64'(r2_n2[31:1]);
      pnum_n[i + 3] = (64'(r2_cr[i]) << 30) + 64'(r2_n2[31:1]);
    end
  end

  logic             r3_v, r3_zero;
  logic [2:0]       r3_sgn;
  logic [2:0][15:0] r3_ab;
  logic [4:0]       r3_half;
  logic [61:0]      r3_m;
  logic [5:0][63:0] r3_pnum;
  logic [31:0]      r3_n2;

  always_ff @(posedge clk) begin
    if (rst) r3_v <= 1'b0;
    else if (en) r3_v <= r2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_m    <= 62'(r2_n2) << {half_n, 1'b0};
      r3_half <= half_n;
      r3_ab   <= r2_ab;
      r3_sgn  <= r2_sgn;
      r3_zero <= r2_zero;
      r3_pnum <= pnum_n;
      r3_n2   <= r2_n2;
    end
  end

  // ---------------- axis products u_i*u_j, order 00 11 22 01 02 12
  logic [5:0][31:0] pq, pq_d;

  for (genvar i = 0; i < 6; i++) begin : g_pdiv
    aar_div #(.DW(32), .QW(DIV_QW)) u_pdiv (
      .clk (clk),
      .en  (en),
      .num (r3_pnum[i]),
      .den (r3_n2),
      .quo (pq[i])
    );
  end

  aar_delay #(.W(6 * 32), .DEPTH(PQ_DLY)) u_pq_dly (
    .clk (clk), .rst (rst), .en (en), .d (pq), .q (pq_d)
  );

  // ---------------- length root and unit axis
  logic [30:0]      len;
  logic [4:0]       half_a;
  logic [2:0][15:0] ab_a;

  aar_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .m    (r3_m),
    .root (len)
  );

  aar_delay #(.W(5 + 48), .DEPTH(A_DLY)) u_a_dly (
    .clk (clk), .rst (rst), .en (en),
    .d   ({r3_half, r3_ab}),
    .q   ({half_a, ab_a})
  );

  logic [6:0]       ush;
  logic [2:0][62:0] unum_n;
  logic [2:0][62:0] r36_unum;
  logic [30:0]      r36_len;

  assign ush = 7'd30 + 7'(half_a);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unum_n[i] = 63'((77'(ab_a[i]) << ush) + 77'(len[30:1]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r36_unum <= unum_n;
      r36_len  <= len;
    end
  end

  logic [2:0][31:0] uq;

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    aar_div #(.DW(31), .QW(DIV_QW)) u_udiv (
      .clk (clk),
      .en  (en),
      .num (r36_unum[i]),
      .den (r36_len),
      .quo (uq[i])
    );
  end

  // ---------------- sine, cosine
  logic signed [31:0] s_raw, c_raw, s_d, c_d;
  logic signed [33:0] omc_raw, omc_d;

  aar_sincos u_sincos (
    .clk     (clk),
    .en      (en),
    .angle   (r0_ang),
    .sin_q30 (s_raw),
    .cos_q30 (c_raw),
    .omc     (omc_raw)
  );

  aar_delay #(.W(98), .DEPTH(SC_DLY)) u_sc_dly (
    .clk (clk), .rst (rst), .en (en),
    .d   ({s_raw, c_raw, omc_raw}),
    .q   ({s_d, c_d, omc_d})
  );

  // ---------------- valid, zero flag and axis signs
  logic       v68, zero68;
  logic [2:0] sgn68;

  aar_delay #(.W(5), .DEPTH(SIDE_DLY)) u_side_dly (
    .clk (clk), .rst (rst), .en (en),
    .d   ({r3_v, r3_zero, r3_sgn}),
    .q   ({v68, zero68, sgn68})
  );

  // ---------------- multiply operands as magnitude and sign
  // terms: diag (1-p_ii)*c, p_ij*(1-c), u_k*s
  logic [8:0][32:0] a_n, b_n;
  logic [8:0]       neg_n;
  logic [2:0]       psgn;

  assign psgn = {sgn68[1] ^ sgn68[2], sgn68[0] ^ sgn68[2], sgn68[0] ^ sgn68[1]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_n[i]       = 33'(34'(Q30_ONE) - 34'(pq_d[i]));
      b_n[i]       = mag34(34'(c_d));
      neg_n[i]     = c_d[31];
      a_n[i + 3]   = 33'(pq_d[i + 3]);
      b_n[i + 3]   = mag34(omc_d);
      neg_n[i + 3] = psgn[i] ^ omc_d[33];
      a_n[i + 6]   = 33'(uq[i]);
      b_n[i + 6]   = mag34(34'(s_d));
      neg_n[i + 6] = sgn68[i] ^ s_d[31];
    end
  end

  logic             f0_v, f0_zero;
  logic [8:0][32:0] f0_a, f0_b;
  logic [8:0]       f0_neg;
  logic [2:0][31:0] f0_pii;

  always_ff @(posedge clk) begin
    if (rst) f0_v <= 1'b0;
    else if (en) f0_v <= v68;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_a    <= a_n;
      f0_b    <= b_n;
      f0_neg  <= neg_n;
      f0_zero <= zero68;
      for (int i = 0; i < 3; i++) f0_pii[i] <= pq_d[i];
    end
  end

  // ---------------- products
  logic             f1_v, f1_zero;
  logic [8:0][65:0] f1_prod;
  logic [8:0]       f1_neg;
  logic [2:0][31:0] f1_pii;

  always_ff @(posedge clk) begin
    if (rst) f1_v <= 1'b0;
    else if (en) f1_v <= f0_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) f1_prod[j] <= 66'(f0_a[j]) * 66'(f0_b[j]);
      f1_neg  <= f0_neg;
      f1_pii  <= f0_pii;
      f1_zero <= f0_zero;
    end
  end

  // ---------------- round to Q30 and combine
  logic signed [37:0] t [9];
  logic signed [37:0] e_n [9];

  always_comb begin
    logic [65:0] rr;
    for (int j = 0; j < 9; j++) begin
      rr   = f1_prod[j] + (66'd1 << 29);
      t[j] = f1_neg[j] ? -$signed({2'b00, rr[65:30]}) : $signed({2'b00, rr[65:30]});
    end
    e_n[0] = $signed({6'd0, f1_pii[0]}) + t[0];
    e_n[4] = $signed({6'd0, f1_pii[1]}) + t[1];
    e_n[8] = $signed({6'd0, f1_pii[2]}) + t[2];
    e_n[1] = t[3] - t[8];
    e_n[3] = t[3] + t[8];
    e_n[2] = t[4] + t[7];
    e_n[6] = t[4] - t[7];
    e_n[5] = t[5] - t[6];
    e_n[7] = t[5] + t[6];
  end

  logic               f2_v, f2_zero;
  logic signed [37:0] f2_e [9];

  always_ff @(posedge clk) begin
    if (rst) f2_v <= 1'b0;
    else if (en) f2_v <= f1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_e    <= e_n;
      f2_zero <= f1_zero;
    end
  end

  // ---------------- Q2.14 conversion, identity on zero axis
  logic             p_v, p_z;
  logic [8:0][15:0] p_m;

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= f2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_z <= f2_zero;
      for (int j = 0; j < 9; j++) begin
        if (f2_zero) p_m[j] <= (j % 4 == 0) ? Q14_ONE : 16'd0;
        else         p_m[j] <= to_q14(f2_e[j]);
      end
    end
  end

  // ---------------- output register and skid entry
  logic [8:0][15:0] out_m, skid_m;
  logic             out_z, skid_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!result_stall) skid_v <= 1'b0;
    end else if (out_v && result_stall) begin
      if (p_v) skid_v <= 1'b1;
    end else begin
      out_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!result_stall) begin
        out_m <= skid_m;
        out_z <= skid_z;
      end
    end else if (out_v && result_stall) begin
      skid_m <= p_m;
      skid_z <= p_z;
    end else begin
      out_m <= p_m;
      out_z <= p_z;
    end
  end

  assign result_valid = out_v;
  assign zero_axis    = out_z;
  assign m00 = out_m[0];
  assign m01 = out_m[1];
  assign m02 = out_m[2];
  assign m10 = out_m[3];
  assign m11 = out_m[4];
  assign m12 = out_m[5];
  assign m20 = out_m[6];
  assign m21 = out_m[7];
  assign m22 = out_m[8];

endmodule
